// ----- design/qspf_pkg.sv -----
// Shared types and constants for the quadratic spline path follower.
package qspf_pkg;

  localparam int MAX_NODES = 64;
  localparam int PH_W      = 22;
  localparam int IDX_W     = 7;
  localparam int DIV_STEPS = 12;
  localparam int LANES     = 6;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_SPEED      = 1'b1;

  localparam logic [6:0]  NODE_COUNT_RST = 7'd1;
  localparam logic [23:0] SPEED_RST      = 24'd32768;
  localparam logic [22:0] HALF_Q16       = 23'd32768;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_DIV, S_FIX, S_RD0, S_RD1, S_RD2,
    S_SETUP, S_L0, S_L1, S_L2, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    K_ONE, K_TWO, K_FIRST, K_QUAD, K_LAST
  } kind_t;

endpackage

// ----- design/qspf_if.sv -----
// Request and result channel interfaces of the spline path follower.
interface qspf_in_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [5:0]           node_index;
  logic signed [CW-1:0] node_pos_x;
  logic signed [CW-1:0] node_pos_y;
  logic signed [CW-1:0] node_pos_z;
  logic signed [CW-1:0] node_look_x;
  logic signed [CW-1:0] node_look_y;
  logic signed [CW-1:0] node_look_z;
  logic [19:0]          time_step;
  logic                 look_enable;
  logic [21:0]          new_phase;

  modport source(output valid, op, node_index, node_pos_x, node_pos_y, node_pos_z,
                 node_look_x, node_look_y, node_look_z, time_step, look_enable,
                 new_phase, input ready);
  modport sink(input valid, op, node_index, node_pos_x, node_pos_y, node_pos_z,
               node_look_x, node_look_y, node_look_z, time_step, look_enable,
               new_phase, output ready);
endinterface

interface qspf_out_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  logic signed [CW-1:0] look_x;
  logic signed [CW-1:0] look_y;
  logic signed [CW-1:0] look_z;
  logic                 look_valid;
  logic [21:0]          phase_out;

  modport source(output valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
                 look_valid, phase_out, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
               look_valid, phase_out, output ready);
endinterface

// ----- design/qspf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module qspf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/quadratic_spline_path_follower.sv -----
// Top level of the quadratic B-spline path follower.
//
// Holds up to MAX_NODES control nodes (position and look point, Q16.16) in one
// node RAM and a Q6.16 phase. A node write or a set-phase request completes
// without leaving the idle state. A tick request advances the phase by
// speed*time_step/2^16, wraps it into one period of node_count-1, reads up to
// three nodes from the RAM (one port, one node per cycle) and evaluates the
// spline with one lerp unit per coordinate, three lerps in sequence. A tick
// whose phase needs a wrap first runs the bit-serial remainder unit (12 steps,
// one quotient bit per cycle) and a correction step. Requests are taken one at
// a time; the result sits in an output register, so the next request is taken
// while a result waits. Node writes after reset define node contents;
// unwritten nodes read as whatever the RAM holds.
module quadratic_spline_path_follower
  import qspf_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  qspf_in_if.sink       in_ch,
  qspf_out_if.source    out_ch,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  localparam int CW = COORD_WIDTH;
  localparam int AW = $clog2(MAX_NODES);

  // Lerp a + floor(t*(b-a)/2^16), t in 0..65536.
  function automatic logic signed [CW-1:0] lerp_f(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b,
                                                  input logic [16:0] t);
    logic signed [CW:0]    d;
    logic signed [CW+18:0] p;
    d = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
    p = $signed({1'b0, t}) * d;
    return CW'(a + (p >>> 16));
  endfunction

  // Midpoint floor((a+b)/2).
  function automatic logic signed [CW-1:0] mid_f(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    logic signed [CW:0] s;
    s = $signed({a[CW-1], a}) + $signed({b[CW-1], b});
    return s[CW:1];
  endfunction

  // Configuration registers
  logic [6:0]         node_count_r;
  logic signed [23:0] speed_r;

  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_SPEED) ? {{8{speed_r[23]}}, speed_r}
                                                  : {25'd0, node_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      speed_r      <= SPEED_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_NODE_COUNT) begin
        node_count_r <= cfg_pwdata[6:0];
      end else begin
        speed_r <= cfg_pwdata[23:0];
      end
    end
  end

  // Node count in use, period in whole nodes and in Q6.16
  logic [IDX_W-1:0] n_sat;
  logic [IDX_W-1:0] d_w;
  logic [22:0]      period_w;

  always_comb begin
    if (node_count_r == '0) begin
      n_sat = IDX_W'(1);
    end else if (int'(node_count_r) > MAX_NODES) begin
      n_sat = IDX_W'(MAX_NODES);
    end else begin
      n_sat = node_count_r;
    end
    d_w      = n_sat - IDX_W'(1);
    period_w = {d_w, 16'd0};
  end

  // Control state
  state_t state_r, state_nxt;
  logic   in_fire;
  logic   out_valid_r;
  logic   out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Phase and wrap datapath; the step product is registered at acceptance and
  // the sum is formed in S_ADD from that product
  logic [PH_W-1:0]    phase_r;
  logic signed [44:0] prod_r;
  logic               look_r;
  logic               neg_r;
  logic [11:0]        xi_r;
  logic [15:0]        xf_r;
  logic [6:0]         rem_r;
  logic [3:0]         div_cnt_r;

  logic signed [29:0] ph_sum;
  logic               phs_neg;
  logic               phs_gtp;
  logic [29:0]        x_w;
  logic [7:0]         rem_ext;
  logic [6:0]         rem_nxt;
  logic [22:0]        r_w;
  logic [22:0]        fix_w;

  assign ph_sum  = {8'd0, phase_r} + {prod_r[44], prod_r[44:16]};
  assign phs_neg = ph_sum[29];
  assign phs_gtp = !phs_neg && (ph_sum > $signed({7'd0, period_w}));
  assign x_w     = phs_neg ? 30'(-ph_sum) : 30'(ph_sum - 30'sd1);
  assign rem_ext = {rem_r, xi_r[11]};
  assign rem_nxt = (rem_ext >= {1'b0, d_w}) ? 7'(rem_ext - {1'b0, d_w}) : rem_ext[6:0];
  assign r_w     = {rem_r, xf_r};
  assign fix_w   = neg_r ? ((r_w == '0) ? 23'd0 : period_w - r_w) : r_w + 23'd1;

  // Segment selection from the wrapped phase
  kind_t            kind_w;
  logic [IDX_W-1:0] i0_w, i1_w, i2_w;
  logic [16:0]      tsel_w;
  logic [22:0]      ph23, upper_w, d2_w, dl_w;

  always_comb begin
    ph23    = {1'b0, phase_r};
    upper_w = period_w - HALF_Q16;
    d2_w    = ph23 - HALF_Q16;
    dl_w    = ph23 - upper_w;
    kind_w  = K_LAST;
    i0_w    = n_sat - IDX_W'(2);
    i1_w    = d_w;
    i2_w    = d_w;
    tsel_w  = 17'(dl_w << 1);
    priority if (n_sat == IDX_W'(1)) begin
      kind_w = K_ONE;
      i0_w   = '0;
      i1_w   = '0;
      i2_w   = '0;
      tsel_w = '0;
    end else if (n_sat == IDX_W'(2)) begin
      kind_w = K_TWO;
      i0_w   = '0;
      i1_w   = IDX_W'(1);
      i2_w   = IDX_W'(1);
      tsel_w = ph23[16:0];
    end else if (ph23 < HALF_Q16) begin
      kind_w = K_FIRST;
      i0_w   = '0;
      i1_w   = IDX_W'(1);
      i2_w   = IDX_W'(1);
      tsel_w = {ph23[15:0], 1'b0};
    end else if (ph23 < upper_w) begin
      kind_w = K_QUAD;
      i0_w   = d2_w[22:16];
      i1_w   = d2_w[22:16] + IDX_W'(1);
      i2_w   = d2_w[22:16] + IDX_W'(2);
      tsel_w = {1'b0, d2_w[15:0]};
    end else begin
      kind_w = K_LAST;
    end
  end

  // Node RAM: all six coordinates of a node in one word
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [6*CW-1:0]   ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [6*CW-1:0]   ram_rdata;

  assign ram_we    = in_fire && (in_ch.op == OP_WRITE) && (int'(in_ch.node_index) < MAX_NODES);
  assign ram_waddr = AW'(in_ch.node_index);
  assign ram_wdata = {in_ch.node_look_z, in_ch.node_look_y, in_ch.node_look_x,
                      in_ch.node_pos_z, in_ch.node_pos_y, in_ch.node_pos_x};

  qspf_ram #(.WIDTH(6 * CW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire && in_ch.op == OP_TICK) state_nxt = S_ADD;
      S_ADD: begin
        if (d_w != '0 && (phs_neg || phs_gtp)) state_nxt = S_DIV;
        else state_nxt = S_RD0;
      end
      S_DIV:   if (div_cnt_r == 4'(DIV_STEPS - 1)) state_nxt = S_FIX;
      S_FIX:   state_nxt = S_RD0;
      S_RD0:   state_nxt = S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_L0;
      S_L0:    state_nxt = S_L1;
      S_L1:    state_nxt = S_L2;
      S_L2:    state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Read address per state
  always_comb begin
    unique case (state_r)
      S_RD0:   ram_raddr = AW'(i0_w);
      S_RD1:   ram_raddr = AW'(i1_w);
      S_RD2:   ram_raddr = AW'(i2_w);
      default: ram_raddr = AW'(i0_w);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Phase register and wrap unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      if (in_fire && in_ch.op == OP_SET) begin
        phase_r <= in_ch.new_phase;
      end else if (state_r == S_ADD) begin
        if (d_w == '0) phase_r <= '0;
        else if (!(phs_neg || phs_gtp)) phase_r <= ph_sum[PH_W-1:0];
      end else if (state_r == S_FIX) begin
        phase_r <= fix_w[PH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prod_r <= speed_r * $signed({1'b0, in_ch.time_step});
      look_r <= in_ch.look_enable;
    end
    if (state_r == S_ADD) begin
      neg_r     <= phs_neg;
      xi_r      <= x_w[27:16];
      xf_r      <= x_w[15:0];
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (state_r == S_DIV) begin
      xi_r      <= {xi_r[10:0], 1'b0};
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + 4'd1;
    end
  end

  // Coordinate lanes: capture nodes, form control points, run three lerps
  logic signed [CW-1:0] n0_r [LANES];
  logic signed [CW-1:0] n1_r [LANES];
  logic signed [CW-1:0] a_r  [LANES];
  logic signed [CW-1:0] b_r  [LANES];
  logic signed [CW-1:0] c_r  [LANES];
  logic signed [CW-1:0] q0_r [LANES];
  logic signed [CW-1:0] q1_r [LANES];
  logic signed [CW-1:0] res_r[LANES];
  logic signed [CW-1:0] la_w [LANES];
  logic signed [CW-1:0] lb_w [LANES];
  logic signed [CW-1:0] lr_w [LANES];
  logic signed [CW-1:0] n2_w [LANES];
  logic [16:0]          t_r;
  logic                 lin_r;

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      n2_w[c] = ram_rdata[c*CW +: CW];
      unique case (state_r)
        S_L1: begin
          la_w[c] = b_r[c];
          lb_w[c] = c_r[c];
        end
        S_L2: begin
          la_w[c] = q0_r[c];
          lb_w[c] = q1_r[c];
        end
        default: begin
          la_w[c] = a_r[c];
          lb_w[c] = b_r[c];
        end
      endcase
      lr_w[c] = lerp_f(la_w[c], lb_w[c], t_r);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < LANES; c++) begin
      if (state_r == S_RD1) n0_r[c] <= ram_rdata[c*CW +: CW];
      if (state_r == S_RD2) n1_r[c] <= ram_rdata[c*CW +: CW];
      if (state_r == S_SETUP) begin
        unique case (kind_w)
          K_ONE: begin
            a_r[c] <= n0_r[c];
            b_r[c] <= n0_r[c];
          end
          K_TWO: begin
            a_r[c] <= n0_r[c];
            b_r[c] <= n1_r[c];
          end
          K_FIRST: begin
            a_r[c] <= n0_r[c];
            b_r[c] <= mid_f(n0_r[c], n1_r[c]);
          end
          K_QUAD: begin
            a_r[c] <= mid_f(n0_r[c], n1_r[c]);
            b_r[c] <= n1_r[c];
          end
          default: begin
            a_r[c] <= mid_f(n0_r[c], n1_r[c]);
            b_r[c] <= n1_r[c];
          end
        endcase
        c_r[c] <= mid_f(n1_r[c], n2_w[c]);
      end
      if (state_r == S_L0) q0_r[c] <= lr_w[c];
      if (state_r == S_L1) q1_r[c] <= lr_w[c];
      if (state_r == S_L2) res_r[c] <= lin_r ? q0_r[c] : lr_w[c];
    end
    if (state_r == S_SETUP) begin
      t_r   <= tsel_w;
      lin_r <= (kind_w != K_QUAD);
    end
  end

  // Result register: load when free, drop when taken
  logic signed [CW-1:0] opos_r [3];
  logic signed [CW-1:0] olook_r[3];
  logic                 olv_r;
  logic [PH_W-1:0]      ophase_r;
  logic                 out_load;

  assign out_load = (state_r == S_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int c = 0; c < 3; c++) begin
        opos_r[c]  <= res_r[c];
        olook_r[c] <= look_r ? res_r[c+3] : '0;
      end
      olv_r    <= look_r;
      ophase_r <= phase_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pos_x      = opos_r[0];
  assign out_ch.pos_y      = opos_r[1];
  assign out_ch.pos_z      = opos_r[2];
  assign out_ch.look_x     = olook_r[0];
  assign out_ch.look_y     = olook_r[1];
  assign out_ch.look_z     = olook_r[2];
  assign out_ch.look_valid = olv_r;
  assign out_ch.phase_out  = ophase_r;

  // Remainder stays below the divisor between steps
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_cnt_r != 4'd0) |-> (rem_r < d_w))
    else $error("remainder not reduced below node period");

  // Wrapped phase lands inside one period
  a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIX) |=> ({1'b0, phase_r} <= period_w))
    else $error("phase outside period after wrap");

  // A finished tick with room in the result register shows up as valid
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result lost at output register");
endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the quadratic spline path follower.
module testbench
  import qspf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  node_index;
    logic [31:0] coord [6];
    logic [19:0] time_step;
    logic        look_enable;
    logic [21:0] new_phase;
  } request_t;

  typedef struct {
    logic [31:0] lane [6];
    logic        look_valid;
    logic [21:0] phase_out;
  } pose_t;

  localparam int NODES      = 64;
  localparam int SETTLE     = 40;
  localparam int DRAIN_WAIT = 200000;

  localparam logic [21:0] edge_phases [6] = '{22'd32767, 22'd32768, 22'd229375,
                                             22'd229376, 22'd262144, 22'd98304};

  logic clk;
  logic rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  qspf_in_if  #(.CW(32)) in_ch ();
  qspf_out_if #(.CW(32)) out_ch ();

  quadratic_spline_path_follower dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow of the block's state: node RAM, phase and both registers.
  longint node_mem [NODES][6];
  longint path_phase;
  int     node_count_reg;
  longint speed_reg;

  pose_t  pending_poses [$];
  int     errors;
  bit     calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("quadratic_spline_path_follower verification failed");
    $finish;
  end

  // Gap length: mostly none or short, now and then long; none at all while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // --- predictor -----------------------------------------------------------

  // a + floor(t*(b-a)/2^16), split so the product cannot overflow
  function automatic longint lerp_q16(longint a, longint b, longint t);
    longint d, hi, lo;
    if (t >= 65536) return b;
    d  = b - a;
    hi = d >>> 16;
    lo = d - hi * 65536;
    return a + t * hi + ((t * lo) >>> 16);
  endfunction

  function automatic longint mid_of(longint a, longint b);
    return (a + b) >>> 1;
  endfunction

  function automatic longint eval_lane(int n, longint ph, int c);
    longint upper, d, t, m0, cn, m1;
    int k;
    if (n <= 1) return node_mem[0][c];
    if (n == 2) return lerp_q16(node_mem[0][c], node_mem[1][c], ph);
    upper = (longint'(n - 1) << 16) - 32768;
    // opening straight segment up to phase one half
    if (ph < 32768)
      return lerp_q16(node_mem[0][c], mid_of(node_mem[0][c], node_mem[1][c]), ph * 2);
    if (ph < upper) begin
      d  = ph - 32768;
      k  = int'(d >>> 16);
      t  = d & 64'hFFFF;
      m0 = mid_of(node_mem[k][c], node_mem[k + 1][c]);
      cn = node_mem[k + 1][c];
      m1 = mid_of(node_mem[k + 1][c], node_mem[k + 2][c]);
      return lerp_q16(lerp_q16(m0, cn, t), lerp_q16(cn, m1, t), t);
    end
    // closing straight segment, which owns phase n-1.5 exactly
    return lerp_q16(mid_of(node_mem[n - 2][c], node_mem[n - 1][c]), node_mem[n - 1][c],
                    (ph - upper) * 2);
  endfunction

  function automatic pose_t advance_and_eval(request_t rq);
    pose_t  p;
    int     n;
    longint period, ph, r;
    n = node_count_reg;
    if (n == 0) n = 1;
    if (n > NODES) n = NODES;
    period = longint'(n - 1) << 16;
    ph = path_phase + ((speed_reg * longint'(rq.time_step)) >>> 16);
    if (period == 0) begin
      ph = 0;
    end else if (ph < 0) begin
      r  = (-ph) % period;
      ph = (r != 0) ? period - r : 0;
    end else if (ph > period) begin
      ph = (ph - 1) % period + 1;
    end
    path_phase = ph;
    for (int c = 0; c < 6; c++)
      p.lane[c] = 32'((c < 3 || rq.look_enable) ? eval_lane(n, ph, c) : 64'd0);
    p.look_valid = rq.look_enable;
    p.phase_out  = ph[21:0];
    return p;
  endfunction

  function automatic void track_request(request_t rq);
    if (rq.op == OP_WRITE) begin
      for (int c = 0; c < 6; c++) node_mem[rq.node_index][c] = longint'($signed(rq.coord[c]));
    end else if (rq.op == OP_SET) begin
      path_phase = longint'(rq.new_phase);
    end else if (rq.op == OP_TICK) begin
      pending_poses.insert(pending_poses.size(), advance_and_eval(rq));
    end
  endfunction

  // --- drivers ---------------------------------------------------------------

  // Present one request, hold it until accepted, then leave valid high so a
  // back-to-back request needs no second assignment in the same step.
  task automatic send_request(request_t rq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= rq.op;
    in_ch.node_index  <= rq.node_index;
    in_ch.node_pos_x  <= rq.coord[0];
    in_ch.node_pos_y  <= rq.coord[1];
    in_ch.node_pos_z  <= rq.coord[2];
    in_ch.node_look_x <= rq.coord[3];
    in_ch.node_look_y <= rq.coord[4];
    in_ch.node_look_z <= rq.coord[5];
    in_ch.time_step   <= rq.time_step;
    in_ch.look_enable <= rq.look_enable;
    in_ch.new_phase   <= rq.new_phase;
    do @(posedge clk); while (!in_ch.ready);
    track_request(rq);
  endtask

  // Drop valid and hold until every expected pose has come and the block settles.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic reg_index, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_index, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (reg_index == REG_NODE_COUNT) node_count_reg = int'(value[6:0]);
    else speed_reg = longint'($signed(value[23:0]));
  endtask

  // Reconfigure only while idle, with the bus idle between the two writes.
  task automatic reconfigure(int count, longint spd);
    drain();
    write_reg(REG_NODE_COUNT, count);
    @(posedge clk);
    write_reg(REG_SPEED, 32'(spd));
    @(posedge clk);
  endtask

  // --- request builders ------------------------------------------------------

  function automatic request_t node_write(int idx, logic [31:0] fill);
    request_t rq;
    rq = '{default: '0};
    rq.op = OP_WRITE;
    rq.node_index = 6'(idx);
    for (int c = 0; c < 6; c++) rq.coord[c] = (fill === 'x) ? $urandom() : fill;
    return rq;
  endfunction

  function automatic request_t random_node_write();
    request_t rq;
    rq = '{default: '0};
    rq.op = OP_WRITE;
    rq.node_index = 6'($urandom_range(0, NODES - 1));
    for (int c = 0; c < 6; c++)
      rq.coord[c] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 << 16) - (1 << 16)
                                                : $urandom();
    // keep don't-care tick fields moving too
    rq.time_step = 20'($urandom());
    rq.new_phase = 22'($urandom());
    return rq;
  endfunction

  function automatic request_t tick(logic [19:0] ts, logic look);
    request_t rq;
    rq = '{default: '0};
    rq.op = OP_TICK;
    rq.time_step = ts;
    rq.look_enable = look;
    return rq;
  endfunction

  function automatic request_t set_phase(logic [21:0] ph);
    request_t rq;
    rq = '{default: '0};
    rq.op = OP_SET;
    rq.new_phase = ph;
    return rq;
  endfunction

  // --- result checking -------------------------------------------------------

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // Result channel stalls: short ones mostly, a few long, none while calm.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if (pick_gap() > 0) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pose_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_poses.size() == 0) begin
        $error("pose arrived with none expected");
        errors++;
      end else begin
        want = pending_poses.pop_front();
        check_field("pos_x", want.lane[0], out_ch.pos_x);
        check_field("pos_y", want.lane[1], out_ch.pos_y);
        check_field("pos_z", want.lane[2], out_ch.pos_z);
        check_field("look_x", want.lane[3], out_ch.look_x);
        check_field("look_y", want.lane[4], out_ch.look_y);
        check_field("look_z", want.lane[5], out_ch.look_z);
        check_field("look_valid", 32'(want.look_valid), 32'(out_ch.look_valid));
        check_field("phase_out", 32'(want.phase_out), 32'(out_ch.phase_out));
      end
    end
  end

  // --- tests -----------------------------------------------------------------

  // Reset leaves one node in use: the pose is node 0 and the phase is pinned to 0.
  task automatic test_single_node();
    send_request(node_write(0, 32'h7FFF_FFFF));
    send_request(tick(20'hFFFFF, 1'b1));
    send_request(node_write(0, 32'h8000_0000));
    send_request(set_phase(22'd4128768));
    send_request(tick(20'd0, 1'b0));
    send_request(tick(20'd65536, 1'b1));
  endtask

  // Fill every slot so that later node counts never read an empty node.
  task automatic test_fill_nodes();
    for (int i = 0; i < NODES; i++) send_request(node_write(i, 'x));
  endtask

  // Two nodes: straight lerp, phase exactly at the period, wraps both ways.
  task automatic test_two_nodes();
    reconfigure(2, 65536);
    send_request(set_phase(22'd0));
    send_request(tick(20'd0, 1'b1));
    send_request(tick(20'd65536, 1'b1));
    send_request(set_phase(22'h3FFFFF));
    send_request(tick(20'd3, 1'b0));
    reconfigure(2, -8388608);
    send_request(tick(20'hFFFFF, 1'b1));
  endtask

  // Five nodes: segment borders, including the closing segment at n-1.5.
  task automatic test_segment_edges();
    reconfigure(5, 0);
    foreach (edge_phases[i]) begin
      send_request(set_phase(edge_phases[i]));
      send_request(tick(20'd0, 1'b1));
    end
  endtask

  // Node counts of zero and beyond the store.
  task automatic test_count_limits();
    reconfigure(0, 8388607);
    send_request(tick(20'hFFFFF, 1'b1));
    reconfigure(127, 8388607);
    send_request(tick(20'hFFFFF, 1'b1));
    send_request(tick(20'd1, 1'b0));
    reconfigure(64, 1);
    send_request(set_phase(22'd4128768));
    send_request(tick(20'd1, 1'b1));
  endtask

  // Random mix over several settings; mostly ticks with some rewrites and jumps.
  task automatic test_random_mix();
    request_t rq;
    int count_opts [8] = '{1, 2, 3, 64, 0, 100, 7, 33};
    int sel;
    longint spd;
    for (int blk = 0; blk < 12; blk++) begin
      sel = $urandom_range(0, 7);
      case ($urandom_range(0, 3))
        0: spd = 8388607;
        1: spd = -8388608;
        default: spd = longint'($urandom_range(0, 2 << 20)) - (1 << 20);
      endcase
      reconfigure(count_opts[sel], spd);
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 46; i++) begin
        case ($urandom_range(0, 9))
          0, 1: rq = random_node_write();
          2: rq = set_phase(22'($urandom_range(0, 4128768)));
          default: begin
            rq = tick(20'($urandom()), 1'($urandom_range(0, 1)));
            for (int c = 0; c < 6; c++) rq.coord[c] = $urandom();
            if ($urandom_range(0, 2) == 0) rq.time_step = 20'($urandom_range(0, 2048));
          end
        endcase
        send_request(rq);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    int waited;
    errors = 0;
    calm = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_WRITE;
    in_ch.node_index <= '0;
    in_ch.node_pos_x <= '0;
    in_ch.node_pos_y <= '0;
    in_ch.node_pos_z <= '0;
    in_ch.node_look_x <= '0;
    in_ch.node_look_y <= '0;
    in_ch.node_look_z <= '0;
    in_ch.time_step <= '0;
    in_ch.look_enable <= 1'b0;
    in_ch.new_phase <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    for (int i = 0; i < NODES; i++)
      for (int c = 0; c < 6; c++) node_mem[i][c] = 0;
    path_phase = 0;
    node_count_reg = int'(NODE_COUNT_RST);
    speed_reg = longint'($signed(SPEED_RST));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_single_node();
    test_fill_nodes();
    test_two_nodes();
    test_segment_edges();
    test_count_limits();
    test_random_mix();

    // Stop sending, wait out the remaining poses, then let the block settle.
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_poses.size() != 0 && waited < DRAIN_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (pending_poses.size() != 0) begin
      $error("%0d poses never arrived", pending_poses.size());
      errors++;
    end
    if (errors == 0) begin
      $display("quadratic_spline_path_follower verification clean");
    end else begin
      $display("quadratic_spline_path_follower verification failed");
    end
    $finish;
  end

endmodule
